### design/mlps_pkg.sv
// ----------------------------------------------------------------------------
// mlps_pkg
// Shared types and constants of the multi-lane LED pulse serializer.
// ----------------------------------------------------------------------------
package mlps_pkg;

  localparam int LANES_DEF      = 6;
  localparam int PHASE_BITS_DEF = 10;
  localparam int IN_LANES       = 6;   // lanes carried on the input ports
  localparam int BYTE_W         = 8;
  localparam int BIT_SEL_W      = 3;
  localparam int CFG_W          = 10;
  localparam int CFG_IDX_W      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd2;

  localparam logic [CFG_W-1:0] ZERO_HIGH_RST  = 10'd63;
  localparam logic [CFG_W-1:0] ONE_HIGH_RST   = 10'd105;
  localparam logic [CFG_W-1:0] BIT_PERIOD_RST = 10'd210;

  // item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // broadcast from the bit timer to every lane
  typedef struct packed {
    logic                 take_shift;  // load input byte into shift register
    logic                 take_wait;   // load input byte into waiting slot
    logic                 transfer;    // move waiting slot into shift register
    logic [BIT_SEL_W-1:0] bit_sel;     // 0 selects the msb
    logic                 lane_on;     // a group is on the lines
    logic                 below_zero;  // phase below the zero-high time
    logic                 below_one;   // phase below the one-high time
  } ctrl_t;

  // status of one item, after the item
  typedef struct packed {
    logic sending;
    logic slot_full;
    logic rejected;
    logic done;
  } stat_t;

endpackage

### design/mlps_lane.sv
// ----------------------------------------------------------------------------
// mlps_lane
// One lane: shift byte, waiting byte and the line level of the current bit.
// ----------------------------------------------------------------------------
module mlps_lane (
  input  logic                          clk,
  input  logic [mlps_pkg::BYTE_W-1:0]   in_byte,
  input  mlps_pkg::ctrl_t               ctrl,
  output logic                          level
);
  import mlps_pkg::*;

  logic [BYTE_W-1:0] shift_byte;
  logic [BYTE_W-1:0] wait_byte;
  logic [BYTE_W-1:0] byte_now;

  always_ff @(posedge clk) begin
    if (ctrl.take_shift) begin
      shift_byte <= in_byte;
    end else if (ctrl.transfer) begin
      shift_byte <= wait_byte;
    end
    if (ctrl.take_wait) begin
      wait_byte <= in_byte;
    end
  end

  // a load into an idle block shows the new byte at once
  assign byte_now = ctrl.take_shift ? in_byte : shift_byte;

  // msb first: bit_sel 0 picks bit 7
  assign level = ctrl.lane_on &&
                 (ctrl.below_zero || (byte_now[~ctrl.bit_sel] && ctrl.below_one));

endmodule

### design/mlps_timer.sv
// ----------------------------------------------------------------------------
// mlps_timer
// Bit timing and group sequencing shared by all lanes, plus the config regs.
// ----------------------------------------------------------------------------
module mlps_timer #(
  parameter int PHASE_BITS = mlps_pkg::PHASE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           action,
  input  logic                           last_group,
  input  logic                           cfg_write,
  input  logic [mlps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlps_pkg::CFG_W-1:0]     cfg_data,
  output mlps_pkg::ctrl_t                ctrl,
  output mlps_pkg::stat_t                stat
);
  import mlps_pkg::*;

  localparam int CMP_W = (PHASE_BITS > CFG_W) ? PHASE_BITS : CFG_W;

  logic [CFG_W-1:0] zero_high;
  logic [CFG_W-1:0] one_high;
  logic [CFG_W-1:0] bit_period;

  logic                  active, active_next;
  logic                  wait_valid, wait_valid_next;
  logic                  wait_last, wait_last_next;
  logic                  cur_last, cur_last_next;
  logic [BIT_SEL_W-1:0]  bit_cnt, bit_cnt_next;
  logic [PHASE_BITS-1:0] phase, phase_next;

  logic                  load, tick, fresh, wrap;
  logic [PHASE_BITS-1:0] phase_eff;
  logic [CMP_W:0]        phase_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high  <= ZERO_HIGH_RST;
      one_high   <= ONE_HIGH_RST;
      bit_period <= BIT_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ZERO_HIGH:  zero_high  <= cfg_data;
        CFG_ONE_HIGH:   one_high   <= cfg_data;
        CFG_BIT_PERIOD: bit_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      wait_valid <= 1'b0;
      wait_last  <= 1'b0;
      cur_last   <= 1'b0;
      bit_cnt    <= '0;
      phase      <= '0;
    end else begin
      active     <= active_next;
      wait_valid <= wait_valid_next;
      wait_last  <= wait_last_next;
      cur_last   <= cur_last_next;
      bit_cnt    <= bit_cnt_next;
      phase      <= phase_next;
    end
  end

  assign load  = step && (action == ACT_LOAD);
  assign tick  = step && (action == ACT_TICK);
  assign fresh = load && !active;

  // bit ends when the period is reached or the phase counter is saturated
  assign phase_inc = (CMP_W+1)'(phase) + (CMP_W+1)'(1);
  assign wrap      = (phase_inc >= (CMP_W+1)'(bit_period)) || (&phase);
  assign phase_eff = fresh ? '0 : phase;

  always_comb begin
    active_next     = active;
    wait_valid_next = wait_valid;
    wait_last_next  = wait_last;
    cur_last_next   = cur_last;
    bit_cnt_next    = bit_cnt;
    phase_next      = phase;

    ctrl.take_shift = 1'b0;
    ctrl.take_wait  = 1'b0;
    ctrl.transfer   = 1'b0;
    ctrl.bit_sel    = fresh ? '0 : bit_cnt;
    ctrl.lane_on    = active || load;
    ctrl.below_zero = CMP_W'(phase_eff) < CMP_W'(zero_high);
    ctrl.below_one  = CMP_W'(phase_eff) < CMP_W'(one_high);

    stat.rejected = 1'b0;
    stat.done     = 1'b0;

    if (load) begin
      if (!active) begin
        ctrl.take_shift = 1'b1;
        cur_last_next   = last_group;
        active_next     = 1'b1;
        bit_cnt_next    = '0;
        phase_next      = '0;
      end else if (!wait_valid) begin
        ctrl.take_wait  = 1'b1;
        wait_last_next  = last_group;
        wait_valid_next = 1'b1;
      end else begin
        stat.rejected = 1'b1;
      end
    end

    if (tick && active) begin
      if (wrap) begin
        phase_next = '0;
        if (&bit_cnt) begin
          bit_cnt_next = '0;
          stat.done    = cur_last;
          if (wait_valid) begin
            ctrl.transfer   = 1'b1;
            cur_last_next   = wait_last;
            wait_valid_next = 1'b0;
          end else begin
            active_next   = 1'b0;
            cur_last_next = 1'b0;
          end
        end else begin
          bit_cnt_next = bit_cnt + BIT_SEL_W'(1);
        end
      end else begin
        phase_next = phase + PHASE_BITS'(1);
      end
    end

    stat.sending   = active_next;
    stat.slot_full = wait_valid_next;
  end

  a_wait_needs_active: assert property (@(posedge clk) disable iff (rst)
    wait_valid |-> active)
    else $error("waiting group held while idle");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (rst)
    !active |-> (phase == '0) && (bit_cnt == '0))
    else $error("counters not cleared while idle");

  a_reject_keeps_slot: assert property (@(posedge clk) disable iff (rst)
    load && active && wait_valid |=> wait_valid)
    else $error("rejected load disturbed the waiting slot");

endmodule

### design/multi_lane_led_pulse_serializer_unit.sv
// ----------------------------------------------------------------------------
// multi_lane_led_pulse_serializer_unit
// Six one-wire LED data lines driven in lockstep from byte groups.
// ----------------------------------------------------------------------------
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid, in_stall, action, byte_lane0..5, last_group | in
//   out     | out_valid, out_stall, line_levels, sending, slot_full,
//           | load_rejected, frame_done            | out
//   cfg     | cfg_write, cfg_index, cfg_data       | in
//
// One item per cycle unless stalled: every accepted item gives one result
// in the next cycle, held in the output register. Lane array and shared
// bit timer settle in the accepting cycle; unstalled, one item a clock.
// in_stall rises only while the output register holds an untaken result
// and out_stall is high. Synchronous reset clears control state and loads
// the config registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_lane_led_pulse_serializer_unit #(
  parameter int LANES      = mlps_pkg::LANES_DEF,
  parameter int PHASE_BITS = mlps_pkg::PHASE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [mlps_pkg::BYTE_W-1:0]    byte_lane0,
  input  logic [mlps_pkg::BYTE_W-1:0]    byte_lane1,
  input  logic [mlps_pkg::BYTE_W-1:0]    byte_lane2,
  input  logic [mlps_pkg::BYTE_W-1:0]    byte_lane3,
  input  logic [mlps_pkg::BYTE_W-1:0]    byte_lane4,
  input  logic [mlps_pkg::BYTE_W-1:0]    byte_lane5,
  input  logic                           last_group,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mlps_pkg::IN_LANES-1:0]  line_levels,
  output logic                           sending,
  output logic                           slot_full,
  output logic                           load_rejected,
  output logic                           frame_done,
  input  logic                           cfg_write,
  input  logic [mlps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlps_pkg::CFG_W-1:0]     cfg_data
);
  import mlps_pkg::*;

  logic                step;
  ctrl_t               ctrl;
  stat_t               stat;
  logic [BYTE_W-1:0]   port_bytes [IN_LANES];
  logic [BYTE_W-1:0]   lane_bytes [LANES];
  logic [LANES-1:0]    lane_level;
  logic [IN_LANES-1:0] levels_merged;

  // Hold the input while a finished result waits downstream.
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  assign port_bytes[0] = byte_lane0;
  assign port_bytes[1] = byte_lane1;
  assign port_bytes[2] = byte_lane2;
  assign port_bytes[3] = byte_lane3;
  assign port_bytes[4] = byte_lane4;
  assign port_bytes[5] = byte_lane5;

  // Shared timing and group sequencing.
  mlps_timer #(
    .PHASE_BITS (PHASE_BITS)
  ) u_timer (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .action     (action),
    .last_group (last_group),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctrl       (ctrl),
    .stat       (stat)
  );

  // Lane array: lanes past the input ports are fed a zero byte.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    if (k < IN_LANES) begin : g_fed
      assign lane_bytes[k] = port_bytes[k];
    end else begin : g_zero
      assign lane_bytes[k] = '0;
    end

    mlps_lane u_lane (
      .clk     (clk),
      .in_byte (lane_bytes[k]),
      .ctrl    (ctrl),
      .level   (lane_level[k])
    );
  end

  // Merge: only the first lanes reach the line outputs; absent lanes read low.
  for (genvar k = 0; k < IN_LANES; k++) begin : g_merge
    if (k < LANES) begin : g_has
      assign levels_merged[k] = lane_level[k];
    end else begin : g_none
      assign levels_merged[k] = 1'b0;
    end
  end

  // Output register: load on every accepted item, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      line_levels   <= levels_merged;
      sending       <= stat.sending;
      slot_full     <= stat.slot_full;
      load_rejected <= stat.rejected;
      frame_done    <= stat.done;
    end
  end

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted item produced no result");

  a_done_not_on_load: assert property (@(posedge clk) disable iff (rst)
    step && (action == ACT_LOAD) |=> !frame_done)
    else $error("frame_done raised by a load item");

  a_reject_only_on_load: assert property (@(posedge clk) disable iff (rst)
    step && (action == ACT_TICK) |=> !load_rejected)
    else $error("load_rejected raised by a tick item");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-lane LED pulse serializer. Byte groups
// and tick items go in through a queued driver. A cycle-level predictor of
// the six line waveforms and the slot and frame status computes each result.
// A monitor checks every result against it, field by field, across several
// timing settings and under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import mlps_pkg::*;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          HOLD_CYCLES  = 60;     // long receiver hold-off
  localparam int          DRAIN_CYCLES = 6;      // margin for the output register to settle
  localparam int          QUEUE_DEPTH  = 4;      // items kept ahead of the driver
  localparam int          PRINT_CAP    = 40;
  localparam logic [7:0]  MSB_SEL      = 8'h80;  // bit index 0 selects the msb
  localparam logic [CFG_W-1:0] PHASE_TOP = '1;   // largest phase count

  typedef struct packed {
    logic                              action;
    logic                              last;
    logic [IN_LANES-1:0][BYTE_W-1:0]   lanes;
  } line_item_t;

  typedef struct packed {
    logic [IN_LANES-1:0] levels;
    logic                sending;
    logic                slot_full;
    logic                rejected;
    logic                done;
  } line_result_t;

  // every input known from time zero; reset held high from the start
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  action = ACT_TICK;
  logic [BYTE_W-1:0]     byte_lane0 = '0;
  logic [BYTE_W-1:0]     byte_lane1 = '0;
  logic [BYTE_W-1:0]     byte_lane2 = '0;
  logic [BYTE_W-1:0]     byte_lane3 = '0;
  logic [BYTE_W-1:0]     byte_lane4 = '0;
  logic [BYTE_W-1:0]     byte_lane5 = '0;
  logic                  last_group = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [IN_LANES-1:0]   line_levels;
  logic                  sending;
  logic                  slot_full;
  logic                  load_rejected;
  logic                  frame_done;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ZERO_HIGH;
  logic [CFG_W-1:0]      cfg_data = '0;

  multi_lane_led_pulse_serializer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .byte_lane0    (byte_lane0),
    .byte_lane1    (byte_lane1),
    .byte_lane2    (byte_lane2),
    .byte_lane3    (byte_lane3),
    .byte_lane4    (byte_lane4),
    .byte_lane5    (byte_lane5),
    .last_group    (last_group),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .line_levels   (line_levels),
    .sending       (sending),
    .slot_full     (slot_full),
    .load_rejected (load_rejected),
    .frame_done    (frame_done),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  line_item_t    queued_items[$];     // items waiting for the driver
  line_result_t  predicted_lines[$];  // predicted results, oldest first

  int send_idle_pct = 0;   // chance per cycle the sender holds back
  int recv_idle_pct = 0;   // chance per cycle the receiver stalls
  int hold_starts   = 0;   // bumped to request one long receiver hold-off
  int hold_taken    = 0;   // hold-off requests already served
  int hold_left     = 0;   // cycles left in the current hold-off
  int rand_issued   = 0;

  int mismatches = 0;
  int n_results  = 0;
  int n_loads    = 0;
  int n_rejects  = 0;
  int n_frames   = 0;
  int n_settings = 0;

  // --------------------------------------------------------------------------
  // Predictor state: timing registers and the lane shifter, at reset values
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]                 t_zero   = ZERO_HIGH_RST;
  logic [CFG_W-1:0]                 t_one    = ONE_HIGH_RST;
  logic [CFG_W-1:0]                 t_period = BIT_PERIOD_RST;
  logic [IN_LANES-1:0][BYTE_W-1:0]  lane_bytes = '0;
  logic [IN_LANES-1:0][BYTE_W-1:0]  slot_bytes = '0;
  logic                             slot_valid = 1'b0;
  logic                             slot_last  = 1'b0;
  logic                             group_last = 1'b0;
  logic                             group_on   = 1'b0;
  logic [BIT_SEL_W-1:0]             bit_idx    = '0;
  logic [CFG_W-1:0]                 tick_phase = '0;

  // Level of each lane at the present phase; all low while idle.
  // A one bit stays high until the later of the two high times, and a
  // high time at or past the period keeps the lane high all period.
  function automatic logic [IN_LANES-1:0] lane_levels_now();
    logic [BYTE_W-1:0]   sel;
    logic [IN_LANES-1:0] lv;
    lv  = '0;
    sel = MSB_SEL >> bit_idx;
    if (group_on) begin
      for (int k = 0; k < IN_LANES; k++) begin
        if (tick_phase < t_zero || ((lane_bytes[k] & sel) != '0 && tick_phase < t_one))
          lv[k] = 1'b1;
      end
    end
    return lv;
  endfunction

  // Advance the lane shifter by one item and return the result it causes.
  function automatic line_result_t predict_lane_step(line_item_t it);
    line_result_t r;
    int           nxt;
    r = '0;
    if (it.action == ACT_LOAD) begin
      if (!group_on) begin
        // idle: start the group at once at the msb, phase zero
        lane_bytes = it.lanes;
        group_last = it.last;
        group_on   = 1'b1;
        bit_idx    = '0;
        tick_phase = '0;
      end else if (!slot_valid) begin
        slot_bytes = it.lanes;
        slot_last  = it.last;
        slot_valid = 1'b1;
      end else begin
        r.rejected = 1'b1;
      end
      // a load shows the level at the present phase, after the load
      r.levels = lane_levels_now();
    end else begin
      // a tick shows the level during the tick, then advances
      r.levels = lane_levels_now();
      if (group_on) begin
        nxt = int'(tick_phase) + 1;
        // a period below two ends every bit after one tick
        if (nxt >= int'(t_period) || tick_phase == PHASE_TOP) begin
          tick_phase = '0;
          if (bit_idx == BIT_SEL_W'(7)) begin
            bit_idx = '0;
            if (group_last)
              r.done = 1'b1;
            if (slot_valid) begin
              // the waiting group follows with no gap
              lane_bytes = slot_bytes;
              group_last = slot_last;
              slot_valid = 1'b0;
            end else begin
              group_on   = 1'b0;
              group_last = 1'b0;
            end
          end else begin
            bit_idx = bit_idx + BIT_SEL_W'(1);
          end
        end else begin
          tick_phase = CFG_W'(nxt);
        end
      end
    end
    r.sending   = group_on;
    r.slot_full = slot_valid;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    // keep the log short when a whole run goes wrong; the count still grows
    if (mismatches <= PRINT_CAP)
      $display("[%0t] result %0d: %s got %0h, predicted %0h", $time, n_results, field,
               got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued items; hold the payload until it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : item_driver
    line_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // the slot is free: nothing offered, or the offered item goes in now
      if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt        = queued_items.pop_front();
        in_valid   <= 1'b1;
        action     <= nxt.action;
        last_group <= nxt.last;
        byte_lane0 <= nxt.lanes[0];
        byte_lane1 <= nxt.lanes[1];
        byte_lane2 <= nxt.lanes[2];
        byte_lane3 <= nxt.lanes[3];
        byte_lane4 <= nxt.lanes[4];
        byte_lane5 <= nxt.lanes[5];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_taker
    logic stall;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_taken != hold_starts) begin
        hold_taken = hold_starts;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        stall = ($urandom_range(99) < recv_idle_pct);
      end
      out_stall <= stall;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: track register writes, predict accepted items, check results
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : line_monitor
    line_item_t   seen;
    line_result_t want;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ZERO_HIGH:  t_zero   = cfg_data;
          CFG_ONE_HIGH:   t_one    = cfg_data;
          CFG_BIT_PERIOD: t_period = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (predicted_lines.size() == 0) begin
          report_mismatch("result with none pending, levels", int'(line_levels), 0);
        end else begin
          want = predicted_lines.pop_front();
          if (line_levels !== want.levels)
            report_mismatch("line_levels", int'(line_levels), int'(want.levels));
          if (sending !== want.sending)
            report_mismatch("sending", int'(sending), int'(want.sending));
          if (slot_full !== want.slot_full)
            report_mismatch("slot_full", int'(slot_full), int'(want.slot_full));
          if (load_rejected !== want.rejected)
            report_mismatch("load_rejected", int'(load_rejected), int'(want.rejected));
          if (frame_done !== want.done)
            report_mismatch("frame_done", int'(frame_done), int'(want.done));
          if (want.rejected)
            n_rejects++;
          if (want.done)
            n_frames++;
        end
        n_results++;
      end

      if (in_valid && !in_stall) begin
        seen.action   = action;
        seen.last     = last_group;
        seen.lanes[0] = byte_lane0;
        seen.lanes[1] = byte_lane1;
        seen.lanes[2] = byte_lane2;
        seen.lanes[3] = byte_lane3;
        seen.lanes[4] = byte_lane4;
        seen.lanes[5] = byte_lane5;
        if (seen.action == ACT_LOAD)
          n_loads++;
        predicted_lines.push_back(predict_lane_step(seen));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic line_item_t make_item(logic act, logic lst,
                                           logic [IN_LANES-1:0][BYTE_W-1:0] lanes);
    line_item_t it;
    it.action = act;
    it.last   = lst;
    it.lanes  = lanes;
    return it;
  endfunction

  // Mostly ticks with a load now and then; bytes lean toward all-zero and
  // all-one so that both bit values show up on every lane.
  function automatic line_item_t random_item(int load_one_in);
    line_item_t it;
    int         pick;
    it.action = ($urandom_range(load_one_in - 1) == 0) ? ACT_LOAD : ACT_TICK;
    it.last   = ($urandom_range(2) == 0);
    for (int k = 0; k < IN_LANES; k++) begin
      pick = $urandom_range(7);
      it.lanes[k] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : BYTE_W'($urandom);
    end
    return it;
  endfunction

  // Follow the idling plan by how far the random part has got.
  function automatic void set_idle_mix();
    if (rand_issued < 520) begin
      send_idle_pct = 23;
      recv_idle_pct = 70;
    end else if (rand_issued < 1040) begin
      send_idle_pct = 70;
      recv_idle_pct = 23;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  // Hold until every queued item is in and every predicted result is out.
  task automatic wait_drained();
    @(negedge clk);
    while (queued_items.size() != 0 || in_valid || predicted_lines.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Drain, let the output register settle, then load all three timings.
  task automatic set_timing(input logic [CFG_W-1:0] z, input logic [CFG_W-1:0] o,
                            input logic [CFG_W-1:0] p);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_ZERO_HIGH, z);
    write_reg(CFG_ONE_HIGH, o);
    write_reg(CFG_BIT_PERIOD, p);
    n_settings++;
    @(negedge clk);
  endtask

  // One timing setting followed by a stretch of random items. With pressure,
  // request a long receiver hold-off part way in and later pause the sender
  // until everything predicted so far has come back.
  task automatic run_setting(input logic [CFG_W-1:0] z, input logic [CFG_W-1:0] o,
                             input logic [CFG_W-1:0] p, input int count,
                             input int load_one_in, input bit pressure);
    set_timing(z, o, p);
    for (int i = 0; i < count; i++) begin
      while (queued_items.size() > QUEUE_DEPTH)
        @(negedge clk);
      set_idle_mix();
      if (pressure && i == count / 3)
        hold_starts++;
      if (pressure && i == (2 * count) / 3)
        wait_drained();
      queued_items.push_back(random_item(load_one_in));
      rand_issued++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_idle_mix();

    // Directed part, one-tick bit period so each group takes eight ticks:
    // a tick while idle, a load while idle, a load into the empty slot,
    // a load rejected on a full slot, then ticks through both groups so the
    // waiting group follows at once and the last one raises frame_done.
    set_timing(CFG_W'(1), CFG_W'(2), CFG_W'(1));
    queued_items.push_back(make_item(ACT_TICK, 1'b0, '0));
    queued_items.push_back(make_item(ACT_LOAD, 1'b0,
                           {8'h01, 8'h80, 8'h55, 8'hAA, 8'h00, 8'hFF}));
    queued_items.push_back(make_item(ACT_LOAD, 1'b1,
                           {8'h80, 8'h01, 8'hAA, 8'h55, 8'hFF, 8'h00}));
    queued_items.push_back(make_item(ACT_LOAD, 1'b1,
                           {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));
    repeat (17) queued_items.push_back(make_item(ACT_TICK, 1'b1, '1));

    // Random part over several timings, extremes among them
    run_setting(CFG_W'(3),    CFG_W'(6),    CFG_W'(9),    300, 20, 1'b0);
    // one-high time shorter than zero-high time
    run_setting(CFG_W'(7),    CFG_W'(2),    CFG_W'(10),   230, 20, 1'b0);
    // high times past the period
    run_setting(CFG_W'(12),   CFG_W'(15),   CFG_W'(10),   230, 20, 1'b0);
    // every register at its top value
    run_setting(CFG_W'(1023), CFG_W'(1023), CFG_W'(1023),  60, 15, 1'b0);
    run_setting(CFG_W'(1),    CFG_W'(1023), CFG_W'(2),    250, 20, 1'b0);
    run_setting(ZERO_HIGH_RST, ONE_HIGH_RST, BIT_PERIOD_RST, 100, 20, 1'b0);
    run_setting(CFG_W'(2),    CFG_W'(5),    CFG_W'(8),    380, 20, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_lines.size() != 0)
      report_mismatch("results never seen", 0, predicted_lines.size());

    $display("Covered %0d results from %0d loads (%0d rejected) over %0d timing settings,",
             n_results, n_loads, n_rejects, n_settings);
    $display("with %0d frames finished and %0d mismatches.", n_frames, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #(LIMIT_CYCLES * 10);
    $display("Run timed out after %0d cycles", LIMIT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
